### design/four_channel_ramped_dimmer_defines.svh
// ----------------------------------------------------------------------------
// four_channel_ramped_dimmer_defines
// assertion macros shared by the dimmer modules
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_RAMPED_DIMMER_DEFINES_SVH
`define FOUR_CHANNEL_RAMPED_DIMMER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DMR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dmr_pkg.sv
// ----------------------------------------------------------------------------
// dmr_pkg
// types, codes and compare helpers for the four channel ramped dimmer
// ----------------------------------------------------------------------------
package dmr_pkg;

  localparam int NUM_CHANNELS = 4;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [6:0] FULL_PERCENT = 7'd100;
  localparam logic [6:0] DIVIDE_RESET = 7'd8;
  // 255 * round(2^19 / 100), exact floor(r * 255 / 100) after >> 19
  localparam logic [27:0] BYTE_RECIP = 28'd1336965;

  typedef logic [NUM_CHANNELS-1:0][6:0] level_array_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] channel;
    logic [7:0] percent;
  } dmr_in_t;

  typedef struct packed {
    logic [6:0]  read_value;
    logic [11:0] compare_a;
    logic [11:0] compare_b;
    logic [7:0]  compare_c;
    logic [7:0]  compare_d;
  } dmr_out_t;

  // 25 * (100 - ramp) built from shifts
  function automatic logic [11:0] inv_compare(input logic [6:0] ramp);
    logic [11:0] diff;
    diff = {5'd0, FULL_PERCENT - ramp};
    return (diff << 4) + (diff << 3) + diff;
  endfunction

  // ramp * 255 / 100, truncated, via reciprocal multiply
  function automatic logic [7:0] byte_compare(input logic [6:0] ramp);
    logic [27:0] prod;
    prod = {21'd0, ramp} * BYTE_RECIP;
    return prod[26:19];
  endfunction

endpackage

### design/dmr_core.sv
// ----------------------------------------------------------------------------
// dmr_core
// target and ramp state, prescaler, and result formation for one command
// ----------------------------------------------------------------------------
module dmr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data,
  input  logic             take,
  input  dmr_pkg::dmr_in_t cmd,
  input  logic             skid_full,
  output dmr_pkg::dmr_out_t result
);
  import dmr_pkg::*;

  `include "four_channel_ramped_dimmer_defines.svh"

  logic [7:0]   ramp_divide;
  logic [7:0]   tick_prescale;
  logic [7:0]   tick_prescale_next;
  level_array_t target_level;
  level_array_t target_level_next;
  level_array_t ramp_level;
  level_array_t ramp_level_next;
  logic [8:0]   count;
  logic [6:0]   read_value;

  always_comb begin
    target_level_next  = target_level;
    ramp_level_next    = ramp_level;
    tick_prescale_next = tick_prescale;
    count              = {1'b0, tick_prescale} + 9'd1;
    if (take) begin
      unique case (cmd.mode)
        MODE_TICK: begin
          if (count >= {1'b0, ramp_divide}) begin
            tick_prescale_next = 8'd0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
              if (ramp_level[k] > target_level[k]) begin
                ramp_level_next[k] = ramp_level[k] - 7'd1;
              end else if (ramp_level[k] < target_level[k]) begin
                ramp_level_next[k] = ramp_level[k] + 7'd1;
              end
            end
          end else begin
            tick_prescale_next = count[7:0];
          end
        end
        MODE_WRITE: begin
          target_level_next[cmd.channel] =
            (cmd.percent > {1'b0, FULL_PERCENT}) ? FULL_PERCENT : cmd.percent[6:0];
        end
        default: begin
        end
      endcase
    end
    read_value = (cmd.mode == MODE_TICK) ? 7'd0 : target_level_next[cmd.channel];
  end

  assign result.read_value = read_value;
  assign result.compare_a  = inv_compare(ramp_level_next[0]);
  assign result.compare_b  = inv_compare(ramp_level_next[1]);
  assign result.compare_c  = byte_compare(ramp_level_next[2]);
  assign result.compare_d  = byte_compare(ramp_level_next[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_divide   <= {1'b0, DIVIDE_RESET};
      tick_prescale <= 8'd0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        target_level[k] <= FULL_PERCENT;
        ramp_level[k]   <= 7'd0;
      end
    end else begin
      if (cfg_write) begin
        ramp_divide <= cfg_data;
      end
      tick_prescale <= tick_prescale_next;
      target_level  <= target_level_next;
      ramp_level    <= ramp_level_next;
    end
  end

  `DMR_ASSERT_NEXT(a_ramp_only_on_tick, !(take && cmd.mode == MODE_TICK), $stable(ramp_level), "ramp moved without a tick")
  `DMR_ASSERT_NEXT(a_target_only_on_write, !(take && cmd.mode == MODE_WRITE), $stable(target_level), "target moved without a write")
  `DMR_ASSERT_NOW(a_no_take_when_full, skid_full, !take, "command taken while skid full")

endmodule

### design/dmr_skid.sv
// ----------------------------------------------------------------------------
// dmr_skid
// result register with one skid entry between core and result channel
// ----------------------------------------------------------------------------
module dmr_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  dmr_pkg::dmr_out_t data_in,
  output logic              full,
  output logic              res_valid,
  input  logic              res_stall,
  output dmr_pkg::dmr_out_t res
);
  import dmr_pkg::*;

  `include "four_channel_ramped_dimmer_defines.svh"

  logic     skid_valid;
  dmr_out_t skid_data;
  logic     open;

  // output register is free or drains this cycle
  assign open = !res_valid || !res_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (open) begin
        if (skid_valid) begin
          res_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          res_valid <= take;
        end
      end else if (take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (open) begin
      if (skid_valid) begin
        res <= skid_data;
      end else if (take) begin
        res <= data_in;
      end
    end else if (take) begin
      skid_data <= data_in;
    end
  end

  `DMR_ASSERT_NOW(a_skid_implies_out, skid_valid, res_valid, "skid holds data while output empty")
  `DMR_ASSERT_NEXT(a_skid_drains, skid_valid && !res_stall, res_valid && !skid_valid, "skid did not move to output")
  `DMR_ASSERT_NEXT(a_take_shows, take && open && !skid_valid, res_valid, "accepted transfer not presented")

endmodule

### design/four_channel_ramped_dimmer.sv
// ----------------------------------------------------------------------------
// four_channel_ramped_dimmer
// four dimmer channels with slew limited ramps and pwm compare results
// ----------------------------------------------------------------------------
//
//   channel   signals                      payload
//   -------   --------------------------   -----------------------------------
//   command   cmd_valid / cmd_stall        cmd: mode, channel, percent
//   result    res_valid / res_stall        res: read_value, compare_a..d
//   config    cfg_write                    cfg_data: ramp_divide
//
// one command per cycle while cmd_stall is low; each transfer updates state in
// the same cycle and its result is registered into the result or skid register
// a one-entry skid register lets a command transfer while a result is stalled;
// cmd_stall rises only when both the result and skid registers are full
// synchronous active high reset: targets 100, ramps 0, prescaler 0, divide 8
// ----------------------------------------------------------------------------
module four_channel_ramped_dimmer (
  input  logic              clk,
  input  logic              rst,
  // configuration write, ramp_divide only
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  // command channel
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  dmr_pkg::dmr_in_t  cmd,
  // result channel
  output logic              res_valid,
  input  logic              res_stall,
  output dmr_pkg::dmr_out_t res
);
  import dmr_pkg::*;

  logic     take;
  logic     skid_full;
  dmr_out_t result;

  // command transfer: held off only while the skid entry is occupied
  assign cmd_stall = skid_full;
  assign take      = cmd_valid && !skid_full;

  // state update and compare math, all combinational off the current state
  dmr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .take      (take),
    .cmd       (cmd),
    .skid_full (skid_full),
    .result    (result)
  );

  // result register plus skid entry
  dmr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_in   (result),
    .full      (skid_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

### test/four_channel_ramped_dimmer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_ramped_dimmer_tb
// self-checking bench: commands go in through the valid/stall channel, a
// shadow copy of targets, ramps and prescaler predicts every result, and the
// result channel is compared field by field under random idling and stalls
// ----------------------------------------------------------------------------
module four_channel_ramped_dimmer_tb;
  import dmr_pkg::*;

  // mode 3 has no name in the package; the block treats it as a read
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_PCT = 27;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  dmr_in_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  dmr_out_t res;

  // idling switches, and the request for a long receiver hold-off
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic hold_trigger = 1'b0;
  int hold_left = 0;

  // shadow of the dimmer state
  logic [6:0] target_pct [NUM_CHANNELS];
  logic [6:0] ramp_pct [NUM_CHANNELS];
  logic [7:0] prescale_count;
  logic [7:0] ramp_divide_cfg;

  dmr_out_t pending_results [$];
  int fail_count = 0;
  int n_ticks = 0, n_steps = 0, n_writes = 0, n_reads = 0, n_cfg = 0;

  four_channel_ramped_dimmer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // applies one command to the shadow state and returns the compare values
  // seen after the update
  function automatic dmr_out_t dim_levels_after(input dmr_in_t c);
    dmr_out_t r;
    int unsigned next_count;
    r.read_value = 7'd0;
    if (c.mode == MODE_TICK) begin
      n_ticks++;
      next_count = prescale_count + 1;
      // divide of zero also lands here on every tick
      if (next_count >= ramp_divide_cfg) begin
        prescale_count = 8'd0;
        n_steps++;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          if (ramp_pct[k] > target_pct[k]) ramp_pct[k]--;
          else if (ramp_pct[k] < target_pct[k]) ramp_pct[k]++;
        end
      end else begin
        prescale_count = 8'(next_count);
      end
    end else begin
      // oversized targets clamp to full on every channel
      if (c.mode == MODE_WRITE) begin
        n_writes++;
        target_pct[c.channel] = (c.percent > 8'd100) ? 7'd100 : c.percent[6:0];
      end else begin
        n_reads++;
      end
      r.read_value = target_pct[c.channel];
    end
    r.compare_a = 12'(25 * (100 - int'(ramp_pct[0])));
    r.compare_b = 12'(25 * (100 - int'(ramp_pct[1])));
    r.compare_c = 8'((int'(ramp_pct[2]) * 255) / 100);
    r.compare_d = 8'((int'(ramp_pct[3]) * 255) / 100);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // one process watches both channels at the edge; prediction goes first so a
  // result is always matched against commands already transferred
  always @(posedge clk) begin
    dmr_out_t want;
    if (rst) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        target_pct[k] = 7'd100;
        ramp_pct[k] = 7'd0;
      end
      prescale_count = 8'd0;
      ramp_divide_cfg = 8'd8;
      pending_results.delete();
    end else begin
      if (cfg_write) ramp_divide_cfg = cfg_data;
      if (cmd_valid && !cmd_stall) pending_results.push_back(dim_levels_after(cmd));
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no pending expectation");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_value", want.read_value, res.read_value);
          check_field("compare_a", want.compare_a, res.compare_a);
          check_field("compare_b", want.compare_b, res.compare_b);
          check_field("compare_c", want.compare_c, res.compare_c);
          check_field("compare_d", want.compare_d, res.compare_d);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off counted here on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_trigger) begin
      hold_trigger <= 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------------

  // offer one command and hold it until the transfer, then maybe idle a while
  // with junk on the bus
  task automatic send_cmd(input dmr_in_t c);
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    while (tx_idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      cmd_valid <= 1'b0;
      cmd <= dmr_in_t'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [1:0] mode, input logic [1:0] ch,
                             input logic [7:0] pct);
    dmr_in_t c;
    c.mode = mode;
    c.channel = ch;
    c.percent = pct;
    send_cmd(c);
  endtask

  // sender pauses until every result is back
  task automatic wait_drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // divider writes only happen with the block idle
  task automatic set_ramp_divide(input logic [7:0] value);
    wait_drain();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    n_cfg++;
  endtask

  // random command; tick_pct sets how often the ramps are pushed along
  function automatic dmr_in_t rand_cmd(input int unsigned tick_pct);
    dmr_in_t c;
    int unsigned pick;
    c.channel = 2'($urandom_range(3));
    c.percent = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < tick_pct) c.mode = MODE_TICK;
    else begin
      pick = $urandom_range(99);
      if (pick < 55) c.mode = MODE_WRITE;
      else if (pick < 85) c.mode = MODE_READ;
      else c.mode = MODE_UNUSED;
      pick = $urandom_range(99);
      if (pick < 50) c.percent = 8'($urandom_range(100));
      else if (pick < 70) c.percent = 8'($urandom_range(255, 101));
      else begin
        case (pick % 3)
          0: c.percent = 8'd0;
          1: c.percent = 8'd100;
          default: c.percent = 8'd255;
        endcase
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every target reads 100 and every ramp sits at zero after reset
  task automatic test_reset_values();
    for (int k = 0; k < NUM_CHANNELS; k++) send_fields(MODE_READ, 2'(k), 8'd0);
  endtask

  // write extremes, including values above full that must clamp
  task automatic test_write_clamp();
    send_fields(MODE_WRITE, 2'd0, 8'd0);
    send_fields(MODE_WRITE, 2'd1, 8'd255);
    send_fields(MODE_WRITE, 2'd2, 8'd101);
    send_fields(MODE_WRITE, 2'd3, 8'd100);
    send_fields(MODE_WRITE, 2'd2, 8'd128);
    send_fields(MODE_WRITE, 2'd3, 8'd1);
  endtask

  // mode 3 reads without touching state
  task automatic test_unused_mode();
    send_fields(MODE_UNUSED, 2'd1, 8'd255);
    send_fields(MODE_UNUSED, 2'd3, 8'd0);
  endtask

  // divider of one: every tick moves each ramp not yet at its target one step
  task automatic test_tick_ramp();
    set_ramp_divide(8'd1);
    for (int i = 0; i < 6; i++) send_fields(MODE_TICK, 2'(i), 8'($urandom));
  endtask

  // prescaler above a freshly lowered divider steps on the next tick
  task automatic test_prescale_lowered();
    set_ramp_divide(8'd255);
    for (int i = 0; i < 5; i++) send_fields(MODE_TICK, 2'd0, 8'd0);
    set_ramp_divide(8'd2);
    send_fields(MODE_TICK, 2'd0, 8'd0);
    send_fields(MODE_READ, 2'd2, 8'd0);
  endtask

  task automatic test_random_phase(input logic [7:0] divide, input int count,
                                   input int unsigned tick_pct);
    set_ramp_divide(divide);
    for (int i = 0; i < count; i++) send_cmd(rand_cmd(tick_pct));
  endtask

  // long stretch with no idling on either side
  task automatic test_no_idle(input int count);
    tx_idle_on <= 1'b0;
    rx_idle_on <= 1'b0;
    test_random_phase(8'($urandom_range(12, 2)), count, 60);
    tx_idle_on <= 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // receiver holds off while commands keep coming, so the input backs up
  task automatic test_backpressure();
    wait_drain();
    tx_idle_on <= 1'b0;
    hold_trigger <= 1'b1;
    for (int i = 0; i < 40; i++) send_cmd(rand_cmd(50));
    tx_idle_on <= 1'b1;
    wait_drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_write_clamp();
    test_unused_mode();
    test_tick_ramp();
    test_prescale_lowered();

    test_random_phase(8'd1, 450, 55);
    test_random_phase(8'd0, 250, 85);
    test_random_phase(8'd255, 100, 60);
    test_no_idle(150);
    test_random_phase(8'($urandom_range(12, 2)), 200, 65);
    test_backpressure();
    test_random_phase(8'd3, 150, 70);
    test_random_phase(8'd1, 50, 40);

    wait_drain();
    repeat (5) @(posedge clk);

    $display("covered %0d ticks (%0d ramp steps), %0d target writes, %0d target reads",
             n_ticks, n_steps, n_writes, n_reads);
    $display("over %0d ramp_divide settings incl. 0, 1, 255, idle stretches and a long hold",
             n_cfg);
    if (fail_count == 0) begin
      $display("four_channel_ramped_dimmer test passed");
    end else begin
      $display("four_channel_ramped_dimmer test failed");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #400000;
    $display("four_channel_ramped_dimmer test failed");
    $finish;
  end

endmodule
